@@ src/bams_pkg.sv @@
// Shared types and constants of the buzzer melody sequencer.
// Used by the register block, the alarm queue, the note memory and the top level.
`default_nettype none

package bams_pkg;

    // Field widths
    localparam int unsigned TONE_W      = 16;
    localparam int unsigned END_W       = 24;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned INTERVAL_W  = 16;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_ADDR_W  = 5;
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned OUT_TDATA_W = 24;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd5000;
    localparam logic [POS_W-1:0]      LAST_RST     = 8'd1;

    // Register map, one word each
    typedef enum logic [2:0] {
        REG_WARN_INTERVAL = 3'd0,
        REG_REMOTE_EN     = 3'd1,
        REG_MOTOR_EN      = 3'd2,
        REG_REFEREE_EN    = 3'd3,
        REG_START_LAST    = 3'd4,
        REG_MOTOR_LAST    = 3'd5,
        REG_REMOTE_LAST   = 3'd6,
        REG_BG_LAST       = 3'd7
    } reg_idx_t;

    // Song numbers in the note table
    typedef logic [1:0] song_t;
    localparam song_t SONG_START  = 2'd0;
    localparam song_t SONG_MOTOR  = 2'd1;
    localparam song_t SONG_REMOTE = 2'd2;
    localparam song_t SONG_BG     = 2'd3;

    // Playing / alarm codes
    typedef logic [1:0] play_t;
    localparam play_t PLAYING_IDLE   = 2'd0;
    localparam play_t PLAYING_START  = 2'd1;
    localparam play_t PLAYING_MOTOR  = 2'd2;
    localparam play_t PLAYING_REMOTE = 2'd3;

    // Buzzer commands
    typedef enum logic [1:0] {
        CMD_KEEP = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_t;

    // What the second stage does with a request
    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_PLAY = 2'd1,
        MODE_OFF  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [END_W-1:0]  end_ms;
    } note_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0]       warn_interval;
        logic                        remote_en;
        logic                        motor_en;
        logic                        referee_en;
        logic [3:0][POS_W-1:0]       song_last;
    } cfg_t;

    typedef struct packed {
        logic push_remote;
        logic push_motor;
        logic pop_en;
    } q_req_t;

    typedef struct packed {
        logic  pop;
        play_t code;
    } q_rsp_t;

endpackage

`default_nettype wire

@@ src/buzzer_alarm_melody_sequencer_unit.sv @@
// Buzzer melody sequencer top level: request decode, alarm check, note stage.
// Depends on bams_pkg, bams_cfg_regs, bams_note_mem and bams_alarm_queue.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready| tick or note load request
//  m_*     | out | m_tvalid/m_tready| one buzzer command per request
//  apb     | in  | psel/penable     | configuration registers, 4-byte stride
//
// Each request is handled in stages: the accept cycle checks the flags, updates the
// alarm queue and reads the current and next note from the note table; the
// second stage compares the elapsed time and commits the playback state once the
// output register is free; s_tready is low while it holds a request (state interlock).
// The output register lets a new request enter while a result waits.
// Reset is asynchronous; the note table is not cleared and needs no pass.
`default_nettype none

module buzzer_alarm_melody_sequencer_unit #(
    parameter int unsigned NOTES_PER_SONG = 256,
    parameter int unsigned QUEUE_DEPTH    = 10,
    parameter int unsigned TIME_BITS      = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // tdata: now_ms[31:0], remote_offline, motor_lost, referee_offline,
    //        load_song[1:0], load_index[7:0], load_tone[15:0], load_end_ms[23:0], pad
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bams_pkg::IN_TDATA_W-1:0]  s_tdata,
    // tuser: req_type
    input  wire logic                             s_tuser,
    // tdata: buzzer_cmd[1:0], tone[15:0], volume_level, playing[1:0], song_done, pad
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [bams_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bams_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [bams_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [bams_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import bams_pkg::*;

    localparam int unsigned IDX_W  = $clog2(NOTES_PER_SONG);
    localparam int unsigned ADDR_W = IDX_W + 2;
    localparam int unsigned EXT_W  = ((IDX_W > POS_W + 1) ? IDX_W : POS_W + 1) + 1;
    localparam int unsigned CMP_W  = (TIME_BITS > END_W) ? TIME_BITS : END_W;

    cfg_t   cfg;
    q_req_t qreq;
    q_rsp_t qrsp;

    // Request fields
    logic [TIME_BITS-1:0] now_in;
    logic                 remote_off;
    logic                 motor_off;
    logic                 referee_off;
    song_t                load_song;
    logic [POS_W-1:0]     load_index;
    note_t                load_note;

    // Playback state
    logic                 in_startup_reg;
    logic                 in_startup_next;
    play_t                current_alarm_reg;
    play_t                current_alarm_next;
    logic [POS_W-1:0]     note_position_reg;
    logic [POS_W-1:0]     note_position_next;
    logic [TIME_BITS-1:0] song_start_reg;
    logic [TIME_BITS-1:0] song_start_next;
    logic [TIME_BITS-1:0] last_check_reg;
    logic [TIME_BITS-1:0] last_check_next;

    // First stage
    logic                 s_fire;
    logic                 tick_fire;
    logic                 load_fire;
    logic                 check_due;
    logic [TIME_BITS-1:0] since_check;
    play_t                cur1;
    logic [POS_W-1:0]     pos1;
    song_t                song1;
    mode_t                mode1;
    logic                 vol1;
    logic [POS_W:0]       pa9;
    logic [POS_W:0]       pb9;
    logic [EXT_W-1:0]     pa_ext;
    logic [EXT_W-1:0]     pb_ext;
    logic [EXT_W-1:0]     li_ext;
    logic [ADDR_W-1:0]    rd_addr_a;
    logic [ADDR_W-1:0]    rd_addr_b;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 wr_en;
    note_t                rd_data_a;
    note_t                rd_data_b;

    // Second stage
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    mode_t                s2_mode_reg;
    song_t                s2_song_reg;
    logic                 s2_vol_reg;
    logic [POS_W-1:0]     s2_pos_reg;
    play_t                s2_cur_reg;
    logic [TIME_BITS-1:0] s2_now_reg;
    logic                 s2_in_a_reg;
    logic                 s2_in_b_reg;
    logic [POS_W-1:0]     s2_last_reg;
    logic                 s2_leave;

    logic                 pos_zero;
    logic [POS_W:0]       p9;
    logic [POS_W:0]       pn9;
    logic [TIME_BITS-1:0] start_sel;
    logic [TIME_BITS-1:0] elapsed;
    note_t                note_a;
    note_t                note_b;
    logic                 expired;
    logic                 finish;
    logic                 done;
    logic [POS_W-1:0]     pos_new;
    cmd_t                 res_cmd;
    logic [TONE_W-1:0]    res_tone;
    logic                 res_vol;
    play_t                res_playing;

    // Output register
    logic                 m_valid_reg;
    logic                 m_valid_next;
    cmd_t                 out_cmd_reg;
    logic [TONE_W-1:0]    out_tone_reg;
    logic                 out_vol_reg;
    play_t                out_playing_reg;
    logic                 out_done_reg;

    bams_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bams_alarm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (qreq),
        .rsp   (qrsp)
    );

    bams_note_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (load_note),
        .rd_en     (tick_fire),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Unpack the request
    assign now_in           = s_tdata[TIME_BITS-1:0];
    assign remote_off       = s_tdata[32];
    assign motor_off        = s_tdata[33];
    assign referee_off      = s_tdata[34];
    assign load_song        = s_tdata[36:35];
    assign load_index       = s_tdata[44:37];
    assign load_note.tone   = s_tdata[60:45];
    assign load_note.end_ms = s_tdata[84:61];

    // Hold off new requests while the note stage owns the state
    assign s_tready  = !s2_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign tick_fire = s_fire && !s_tuser;
    assign load_fire = s_fire && s_tuser;

    // Flag check and alarm queue requests
    assign since_check = now_in - last_check_reg;
    assign check_due   = since_check > TIME_BITS'(cfg.warn_interval);

    always_comb
    begin
        qreq.push_remote = tick_fire && !in_startup_reg && check_due
                        && cfg.remote_en && remote_off;
        qreq.push_motor  = tick_fire && !in_startup_reg && check_due
                        && cfg.motor_en && motor_off;
        qreq.pop_en      = tick_fire && !in_startup_reg
                        && (current_alarm_reg == PLAYING_IDLE);
        last_check_next  = (tick_fire && !in_startup_reg && check_due)
                         ? now_in : last_check_reg;
    end

    // Pick the song and the notes to read
    always_comb
    begin
        cur1  = qrsp.pop ? qrsp.code : current_alarm_reg;
        pos1  = qrsp.pop ? '0 : note_position_reg;
        song1 = SONG_BG;
        vol1  = 1'b0;
        mode1 = MODE_PLAY;
        if (s_tuser)
        begin
            mode1 = MODE_LOAD;
        end
        else if (in_startup_reg)
        begin
            song1 = SONG_START;
            vol1  = 1'b1;
        end
        else if (cur1 == PLAYING_MOTOR)
        begin
            song1 = SONG_MOTOR;
            vol1  = 1'b1;
        end
        else if (cur1 == PLAYING_REMOTE)
        begin
            song1 = SONG_REMOTE;
            vol1  = 1'b1;
        end
        else if (cfg.referee_en && referee_off)
        begin
            mode1 = MODE_OFF;
        end

        pa9       = (pos1 == '0) ? (POS_W + 1)'(1) : {1'b0, pos1};
        pb9       = pa9 + (POS_W + 1)'(1);
        pa_ext    = EXT_W'(pa9);
        pb_ext    = EXT_W'(pb9);
        rd_addr_a = {song1, pa_ext[IDX_W-1:0]};
        rd_addr_b = {song1, pb_ext[IDX_W-1:0]};

        li_ext  = EXT_W'(load_index);
        wr_en   = load_fire && (li_ext < EXT_W'(NOTES_PER_SONG));
        wr_addr = {load_song, li_ext[IDX_W-1:0]};
    end

    // Capture the decoded request for the note stage
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s2_mode_reg <= mode1;
            s2_song_reg <= song1;
            s2_vol_reg  <= vol1;
            s2_pos_reg  <= pos1;
            s2_cur_reg  <= cur1;
            s2_now_reg  <= now_in;
            s2_in_a_reg <= pa_ext < EXT_W'(NOTES_PER_SONG);
            s2_in_b_reg <= pb_ext < EXT_W'(NOTES_PER_SONG);
            s2_last_reg <= cfg.song_last[song1];
        end
    end

    // Compare elapsed time against the note end and advance
    always_comb
    begin
        pos_zero  = (s2_pos_reg == '0);
        p9        = pos_zero ? (POS_W + 1)'(1) : {1'b0, s2_pos_reg};
        pn9       = p9 + (POS_W + 1)'(1);
        start_sel = pos_zero ? s2_now_reg : song_start_reg;
        elapsed   = s2_now_reg - start_sel;
        note_a    = s2_in_a_reg ? rd_data_a : '0;
        note_b    = s2_in_b_reg ? rd_data_b : '0;
        expired   = CMP_W'(elapsed) >= CMP_W'(note_a.end_ms);
        finish    = expired && (pn9 > {1'b0, s2_last_reg});
        pos_new   = finish ? '0 : (expired ? pn9[POS_W-1:0] : p9[POS_W-1:0]);

        res_cmd  = CMD_KEEP;
        res_tone = '0;
        res_vol  = 1'b0;
        done     = 1'b0;
        case (s2_mode_reg)
            MODE_LOAD:
            begin
                res_cmd = CMD_KEEP;
            end
            MODE_OFF:
            begin
                res_cmd = CMD_OFF;
            end
            MODE_PLAY:
            begin
                if (finish)
                begin
                    res_cmd = CMD_PLAY;
                    done    = (s2_song_reg != SONG_BG);
                end
                else if (expired)
                begin
                    res_cmd  = CMD_PLAY;
                    res_tone = note_b.tone;
                    res_vol  = s2_vol_reg;
                end
                else if (pos_zero)
                begin
                    res_cmd  = CMD_PLAY;
                    res_tone = note_a.tone;
                    res_vol  = s2_vol_reg;
                end
            end
            default:
            begin
                res_cmd = CMD_KEEP;
            end
        endcase

        in_startup_next    = in_startup_reg;
        current_alarm_next = current_alarm_reg;
        note_position_next = note_position_reg;
        song_start_next    = song_start_reg;
        if (s2_leave)
        begin
            current_alarm_next = done ? PLAYING_IDLE : s2_cur_reg;
            if (done && s2_song_reg == SONG_START)
            begin
                in_startup_next = 1'b0;
            end
            if (s2_mode_reg == MODE_PLAY)
            begin
                note_position_next = pos_new;
                song_start_next    = start_sel;
            end
        end
        res_playing = (s2_leave ? in_startup_next : in_startup_reg)
                    ? PLAYING_START : current_alarm_next;
    end

    // Advance the stage and output handshakes
    assign s2_leave      = s2_valid_reg && (!m_valid_reg || m_tready);
    assign s2_valid_next = s_fire ? 1'b1 : (s2_leave ? 1'b0 : s2_valid_reg);
    assign m_valid_next  = s2_leave ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            in_startup_reg    <= 1'b1;
            current_alarm_reg <= PLAYING_IDLE;
            note_position_reg <= '0;
            song_start_reg    <= '0;
            last_check_reg    <= '0;
        end
        else
        begin
            s2_valid_reg      <= s2_valid_next;
            m_valid_reg       <= m_valid_next;
            in_startup_reg    <= in_startup_next;
            current_alarm_reg <= current_alarm_next;
            note_position_reg <= note_position_next;
            song_start_reg    <= song_start_next;
            last_check_reg    <= last_check_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (s2_leave)
        begin
            out_cmd_reg     <= res_cmd;
            out_tone_reg    <= res_tone;
            out_vol_reg     <= res_vol;
            out_playing_reg <= res_playing;
            out_done_reg    <= done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_done_reg, out_playing_reg, out_vol_reg,
                       out_tone_reg, out_cmd_reg};

`ifndef SYNTHESIS
    a_state_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("request accepted while note stage busy");

    a_startup_once: assert property (@(posedge clk) disable iff (!rst_n)
        !in_startup_reg |=> !in_startup_reg)
        else $error("start song re-entered");

    a_no_alarm_in_startup: assert property (@(posedge clk) disable iff (!rst_n)
        in_startup_reg |-> (current_alarm_reg == PLAYING_IDLE))
        else $error("alarm active during start song");

    a_done_silences: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_done_reg) |->
        (out_cmd_reg == CMD_PLAY && out_tone_reg == '0 && !out_vol_reg))
        else $error("song end without silent note");
`endif

endmodule

`default_nettype wire

@@ src/bams_cfg_regs.sv @@
// Configuration registers behind a simple APB-style port.
// Depends on bams_pkg for the register map and the cfg_t bundle.
`default_nettype none

module bams_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bams_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bams_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [bams_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    output bams_pkg::cfg_t                       cfg
);
    import bams_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel_idx;
    logic     wr_fire;

    assign pready  = 1'b1;
    assign sel_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_fire = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Update the addressed register on a completed write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_fire)
        begin
            case (sel_idx)
                REG_WARN_INTERVAL: cfg_next.warn_interval = pwdata[INTERVAL_W-1:0];
                REG_REMOTE_EN:     cfg_next.remote_en     = pwdata[0];
                REG_MOTOR_EN:      cfg_next.motor_en      = pwdata[0];
                REG_REFEREE_EN:    cfg_next.referee_en    = pwdata[0];
                REG_START_LAST:    cfg_next.song_last[SONG_START]  = pwdata[POS_W-1:0];
                REG_MOTOR_LAST:    cfg_next.song_last[SONG_MOTOR]  = pwdata[POS_W-1:0];
                REG_REMOTE_LAST:   cfg_next.song_last[SONG_REMOTE] = pwdata[POS_W-1:0];
                REG_BG_LAST:       cfg_next.song_last[SONG_BG]     = pwdata[POS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_interval <= INTERVAL_RST;
            cfg_reg.remote_en     <= 1'b0;
            cfg_reg.motor_en      <= 1'b1;
            cfg_reg.referee_en    <= 1'b1;
            cfg_reg.song_last     <= {4{LAST_RST}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (sel_idx)
            REG_WARN_INTERVAL: prdata = CFG_DATA_W'(cfg_reg.warn_interval);
            REG_REMOTE_EN:     prdata = CFG_DATA_W'(cfg_reg.remote_en);
            REG_MOTOR_EN:      prdata = CFG_DATA_W'(cfg_reg.motor_en);
            REG_REFEREE_EN:    prdata = CFG_DATA_W'(cfg_reg.referee_en);
            REG_START_LAST:    prdata = CFG_DATA_W'(cfg_reg.song_last[SONG_START]);
            REG_MOTOR_LAST:    prdata = CFG_DATA_W'(cfg_reg.song_last[SONG_MOTOR]);
            REG_REMOTE_LAST:   prdata = CFG_DATA_W'(cfg_reg.song_last[SONG_REMOTE]);
            REG_BG_LAST:       prdata = CFG_DATA_W'(cfg_reg.song_last[SONG_BG]);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/bams_note_mem.sv @@
// Note table: one write port, two registered read ports.
// Depends on bams_pkg for the note_t entry layout.
`default_nettype none

module bams_note_mem #(
    parameter int unsigned ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire bams_pkg::note_t   wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output bams_pkg::note_t        rd_data_a,
    output bams_pkg::note_t        rd_data_b
);
    import bams_pkg::*;

    localparam int unsigned DEPTH = 2 ** ADDR_W;

    note_t note_mem [DEPTH];
    note_t rd_a_reg;
    note_t rd_b_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            note_mem[wr_addr] <= wr_data;
        end
    end

    // Read the current note and the one after it
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= note_mem[rd_addr_a];
            rd_b_reg <= note_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

@@ src/bams_alarm_queue.sv @@
// Alarm FIFO: up to two pushes (remote first) and one pop per request.
// Depends on bams_pkg for the request/response structs and alarm codes.
`default_nettype none

module bams_alarm_queue #(
    parameter int unsigned DEPTH = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bams_pkg::q_req_t req,
    output bams_pkg::q_rsp_t      rsp
);
    import bams_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    play_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cnt_mid;
    logic [CNT_W-1:0] cnt_pushed;
    logic [PTR_W-1:0] slot_m;
    logic             ok_r;
    logic             ok_m;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // Accept pushes while there is room; drop the rest
    always_comb
    begin
        ok_r       = req.push_remote && (count_reg < CNT_W'(DEPTH));
        cnt_mid    = count_reg + CNT_W'(ok_r);
        ok_m       = req.push_motor && (cnt_mid < CNT_W'(DEPTH));
        cnt_pushed = cnt_mid + CNT_W'(ok_m);
        slot_m     = ok_r ? wrap_inc(tail_reg) : tail_reg;

        rsp.pop  = req.pop_en && (cnt_pushed != '0);
        rsp.code = (count_reg != '0) ? slot_reg[head_reg]
                 : (ok_r ? PLAYING_REMOTE : PLAYING_MOTOR);

        tail_next = tail_reg;
        if (ok_r || ok_m)
        begin
            tail_next = wrap_inc(ok_r && ok_m ? wrap_inc(tail_reg) : tail_reg);
        end
        head_next  = rsp.pop ? wrap_inc(head_reg) : head_reg;
        count_next = cnt_pushed - CNT_W'(rsp.pop);
    end

    // Store pushed codes
    always_ff @(posedge clk)
    begin
        if (ok_r)
        begin
            slot_reg[tail_reg] <= PLAYING_REMOTE;
        end
        if (ok_m)
        begin
            slot_reg[slot_m] <= PLAYING_MOTOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("alarm queue count above depth");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.pop |-> (count_reg != '0 || req.push_remote || req.push_motor))
        else $error("alarm popped from empty queue");
`endif

endmodule

`default_nettype wire

@@ dv/tb_buzzer_alarm_melody_sequencer_unit.sv @@
// Self-checking bench for the buzzer melody sequencer: tick and note load requests,
// register writes over APB, and a predictor that checks every buzzer command word.
// Depends on bams_pkg and buzzer_alarm_melody_sequencer_unit.

module tb_buzzer_alarm_melody_sequencer_unit;
    import bams_pkg::*;

    localparam int NOTE_SLOTS  = 256;
    localparam int ALARM_SLOTS = 10;

    // Request word, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic [23:0] end_ms;
        logic [15:0] tone;
        logic [7:0]  index;
        song_t       song;
        logic        referee_off;
        logic        motor_off;
        logic        remote_off;
        logic [31:0] now_ms;
    } request_t;

    // Command word, lowest field last
    typedef struct packed {
        logic [1:0]  pad;
        logic        song_done;
        play_t       playing;
        logic        volume;
        logic [15:0] tone;
        cmd_t        cmd;
    } buzzer_word_t;

    // Tracks note table, alarm queue and playback; holds the commands still owed
    class buzzer_cmd_scoreboard;
        logic [15:0]  note_tone [4*NOTE_SLOTS];
        logic [23:0]  note_end [4*NOTE_SLOTS];
        logic [15:0]  warn_interval;
        logic         remote_en;
        logic         motor_en;
        logic         referee_en;
        logic [7:0]   last_note [4];
        logic         in_startup;
        play_t        current_alarm;
        int unsigned  note_pos;
        logic [31:0]  song_start;
        logic [31:0]  last_check;
        play_t        alarm_fifo [ALARM_SLOTS];
        int unsigned  fifo_count;
        int unsigned  fifo_head;
        buzzer_word_t outcome;
        buzzer_word_t pending_cmds [$];
        int unsigned  errors;

        function new();
            foreach (note_tone[i])
            begin
                note_tone[i] = '0;
                note_end[i]  = '0;
            end
            foreach (alarm_fifo[i])
                alarm_fifo[i] = PLAYING_IDLE;
            foreach (last_note[i])
                last_note[i] = LAST_RST;
            warn_interval = INTERVAL_RST;
            remote_en     = 1'b0;
            motor_en      = 1'b1;
            referee_en    = 1'b1;
            in_startup    = 1'b1;
            current_alarm = PLAYING_IDLE;
            note_pos      = 0;
            song_start    = '0;
            last_check    = '0;
            fifo_count    = 0;
            fifo_head     = 0;
            errors        = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_WARN_INTERVAL: warn_interval = value[15:0];
                REG_REMOTE_EN:     remote_en = value[0];
                REG_MOTOR_EN:      motor_en = value[0];
                REG_REFEREE_EN:    referee_en = value[0];
                REG_START_LAST:    last_note[SONG_START] = value[7:0];
                REG_MOTOR_LAST:    last_note[SONG_MOTOR] = value[7:0];
                REG_REMOTE_LAST:   last_note[SONG_REMOTE] = value[7:0];
                REG_BG_LAST:       last_note[SONG_BG] = value[7:0];
                default:           ;
            endcase
        endfunction

        // Positions past the table read as a silent note ending at zero
        function void fetch_note(song_t song, int unsigned pos,
                                 output logic [15:0] tone, output logic [23:0] end_ms);
            if (pos < NOTE_SLOTS)
            begin
                tone   = note_tone[int'(song) * NOTE_SLOTS + pos];
                end_ms = note_end[int'(song) * NOTE_SLOTS + pos];
            end
            else
            begin
                tone   = '0;
                end_ms = '0;
            end
        endfunction

        function void play_tone(logic [15:0] tone, logic vol);
            outcome.cmd    = CMD_PLAY;
            outcome.tone   = tone;
            outcome.volume = vol;
        endfunction

        // Advance one song by one tick; a later command overrides an earlier one
        function bit step_song(song_t song, logic vol, logic [31:0] now_t);
            logic [15:0] tone;
            logic [23:0] end_ms;
            logic [31:0] elapsed;
            int unsigned pos;
            bit          finished;
            pos      = note_pos;
            finished = 1'b0;
            if (pos == 0)
            begin
                song_start = now_t;
                pos = 1;
                fetch_note(song, pos, tone, end_ms);
                play_tone(tone, vol);
            end
            fetch_note(song, pos, tone, end_ms);
            elapsed = now_t - song_start;
            if (elapsed >= {8'd0, end_ms})
            begin
                pos++;
                if (pos > last_note[song])
                begin
                    finished = 1'b1;
                    pos = 0;
                    play_tone(16'd0, 1'b0);
                end
                else
                begin
                    fetch_note(song, pos, tone, end_ms);
                    play_tone(tone, vol);
                end
            end
            note_pos = pos;
            return finished;
        endfunction

        // Drop the alarm when the queue is full
        function void push_alarm(play_t code);
            if (fifo_count < ALARM_SLOTS)
            begin
                alarm_fifo[(fifo_head + fifo_count) % ALARM_SLOTS] = code;
                fifo_count++;
            end
        endfunction

        function void accept_request(logic load, request_t rq);
            logic [31:0] since_check;
            outcome = '0;
            if (load)
            begin
                note_tone[int'(rq.song) * NOTE_SLOTS + int'(rq.index)] = rq.tone;
                note_end[int'(rq.song) * NOTE_SLOTS + int'(rq.index)]  = rq.end_ms;
            end
            else if (in_startup)
            begin
                if (step_song(SONG_START, 1'b1, rq.now_ms))
                begin
                    in_startup        = 1'b0;
                    current_alarm     = PLAYING_IDLE;
                    outcome.song_done = 1'b1;
                end
            end
            else
            begin
                // Check the flags at most once per warning interval
                since_check = rq.now_ms - last_check;
                if (since_check > {16'd0, warn_interval})
                begin
                    last_check = rq.now_ms;
                    if (remote_en && rq.remote_off)
                        push_alarm(PLAYING_REMOTE);
                    if (motor_en && rq.motor_off)
                        push_alarm(PLAYING_MOTOR);
                end
                if (fifo_count > 0 && current_alarm == PLAYING_IDLE)
                begin
                    current_alarm = alarm_fifo[fifo_head];
                    fifo_head     = (fifo_head + 1) % ALARM_SLOTS;
                    fifo_count--;
                    note_pos = 0;
                end
                if (current_alarm == PLAYING_MOTOR || current_alarm == PLAYING_REMOTE)
                begin
                    if (step_song(current_alarm == PLAYING_MOTOR ? SONG_MOTOR : SONG_REMOTE,
                                  1'b1, rq.now_ms))
                    begin
                        current_alarm     = PLAYING_IDLE;
                        outcome.song_done = 1'b1;
                    end
                end
                else if (!referee_en || !rq.referee_off)
                    void'(step_song(SONG_BG, 1'b0, rq.now_ms));
                else
                    outcome.cmd = CMD_OFF;
            end
            outcome.playing = in_startup ? PLAYING_START : current_alarm;
            pending_cmds.push_back(outcome);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_cmd(buzzer_word_t got);
            buzzer_word_t want;
            if (pending_cmds.size() == 0)
            begin
                errors++;
                $error("result %h arrived with no request outstanding", got);
                return;
            end
            want = pending_cmds.pop_front();
            compare("buzzer_cmd", want.cmd, got.cmd);
            compare("tone", want.tone, got.tone);
            compare("volume_level", want.volume, got.volume);
            compare("playing", want.playing, got.playing);
            compare("song_done", want.song_done, got.song_done);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    buzzer_cmd_scoreboard cmd_board;

    int unsigned burst_left = 0;
    bit          sender_gaps = 1'b1;
    logic [31:0] clock_ms = '0;
    int unsigned rx_cycles = 0;
    int unsigned hold_left = 0;
    int unsigned segment_left = 0;
    int unsigned rx_mode = 0;
    logic [31:0] directed_times [12] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'd100, 32'd6000,
                                         32'd6001, 32'd20000, 32'd20000, 32'd30000,
                                         32'd40000, 32'h8000_0000, 32'h8000_0001};

    buzzer_alarm_melody_sequencer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check each accepted command word
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            cmd_board.check_cmd(buzzer_word_t'(m_tdata));
    end

    // Drive the result side: long hold-offs now and then, else segments of stall patterns
    always @(posedge clk)
    begin
        if (rx_cycles % 10000 == 1500)
            hold_left = 400;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(16, 240);
                rx_mode      = $urandom_range(0, 2);
            end
            segment_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 2) != 0);
                default: m_tready <= (rx_cycles % 5 != 0);
            endcase
        end
        rx_cycles++;
    end

    function automatic request_t make_tick(logic [31:0] now_ms, logic remote_off,
                                           logic motor_off, logic referee_off);
        request_t rq;
        rq             = '0;
        rq.now_ms      = now_ms;
        rq.remote_off  = remote_off;
        rq.motor_off   = motor_off;
        rq.referee_off = referee_off;
        return rq;
    endfunction

    function automatic request_t make_load(song_t song, logic [7:0] index,
                                           logic [15:0] tone, logic [23:0] end_ms);
        request_t rq;
        rq        = '0;
        rq.song   = song;
        rq.index  = index;
        rq.tone   = tone;
        rq.end_ms = end_ms;
        return rq;
    endfunction

    function automatic logic [7:0] pick_last();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(1, 8));
    endfunction

    function automatic logic [15:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        if (r == 2)
            return 16'($urandom);
        return 16'($urandom_range(1, 300));
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(input logic load, input request_t rq);
        s_tvalid <= 1'b1;
        s_tuser  <= load;
        s_tdata  <= rq;
        do
            @(posedge clk);
        while (!s_tready);
        cmd_board.accept_request(load, rq);
    endtask

    task automatic pace_sender();
        if (!sender_gaps)
            return;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        else
            burst_left--;
    endtask

    // Stop offering until every owed command has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (cmd_board.pending_cmds.size() != 0);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cmd_board.set_reg(idx, value);
    endtask

    task automatic configure(logic [15:0] interval, logic remote_on, logic motor_on,
                             logic referee_on, logic [7:0] start_last, logic [7:0] motor_last,
                             logic [7:0] remote_last, logic [7:0] bg_last);
        drain_results();
        repeat (3)
            @(posedge clk);
        write_reg(REG_WARN_INTERVAL, {16'd0, interval});
        write_reg(REG_REMOTE_EN, {31'd0, remote_on});
        write_reg(REG_MOTOR_EN, {31'd0, motor_on});
        write_reg(REG_REFEREE_EN, {31'd0, referee_on});
        write_reg(REG_START_LAST, {24'd0, start_last});
        write_reg(REG_MOTOR_LAST, {24'd0, motor_last});
        write_reg(REG_REMOTE_LAST, {24'd0, remote_last});
        write_reg(REG_BG_LAST, {24'd0, bg_last});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int unsigned r;
        int unsigned n_items;
        logic [31:0] delta;
        logic [7:0]  idx;
        cmd_board = new();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole note table so that no playback reads an unwritten note
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < NOTE_SLOTS; i++)
            begin
                send_request(1'b1, make_load(song_t'(s), 8'(i),
                    ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                    24'(i * $urandom_range(0, 40))));
                pace_sender();
            end
        end

        // Directed: table extremes, then ticks across the start song, wrap and all flags
        send_request(1'b1, make_load(SONG_START, 8'd1, 16'hFFFF, 24'd0));
        pace_sender();
        send_request(1'b1, make_load(SONG_BG, 8'd255, 16'h0000, 24'hFF_FFFF));
        pace_sender();
        send_request(1'b1, make_load(SONG_MOTOR, 8'd0, 16'h8001, 24'd1));
        pace_sender();
        send_request(1'b1, make_load(SONG_REMOTE, 8'd128, 16'h7FFE, 24'h80_0000));
        pace_sender();
        foreach (directed_times[k])
        begin
            send_request(1'b0, make_tick(directed_times[k], k[0], k[1], k[2] | k[3]));
            pace_sender();
        end
        clock_ms = directed_times[11];

        // Register settings: extremes first, then random ones
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0:       configure(16'd0, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
                1:       configure(16'hFFFF, 1'b0, 1'b0, 1'b0, 8'd1, 8'd1, 8'd1, 8'd1);
                2:       configure(16'd0, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
                default: configure(pick_interval(), 1'($urandom), 1'($urandom),
                                   1'($urandom), pick_last(), pick_last(), pick_last(),
                                   pick_last());
            endcase
            sender_gaps = (ph == 0) || ($urandom_range(0, 3) != 0);
            n_items = (ph == 0) ? 150 : 60;
            for (int k = 0; k < n_items; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    idx = 8'($urandom);
                    send_request(1'b1, make_load(song_t'($urandom), idx,
                        ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                        ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                    : 24'(idx * $urandom_range(0, 40))));
                end
                else
                begin
                    // Mostly small time steps, some long gaps and a few wild jumps
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        delta = 32'd0;
                    else if (r < 75)
                        delta = $urandom_range(1, 60);
                    else if (r < 92)
                        delta = $urandom_range(61, 6000);
                    else if (r < 98)
                        delta = $urandom_range(6001, 70000);
                    else
                        delta = $urandom;
                    clock_ms = clock_ms + delta;
                    send_request(1'b0, make_tick(clock_ms, $urandom_range(0, 2) == 0,
                        $urandom_range(0, 2) == 0, 1'($urandom)));
                end
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                else
                    pace_sender();
            end
        end

        drain_results();
        repeat (10)
            @(posedge clk);
        if (cmd_board.errors == 0 && cmd_board.pending_cmds.size() == 0)
            $display("tb_buzzer_alarm_melody_sequencer_unit: clean");
        else
            $display("tb_buzzer_alarm_melody_sequencer_unit: errors");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #4000000;
        $display("tb_buzzer_alarm_melody_sequencer_unit: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/bams_pkg.sv
src/bams_cfg_regs.sv
src/bams_note_mem.sv
src/bams_alarm_queue.sv
src/buzzer_alarm_melody_sequencer_unit.sv
dv/tb_buzzer_alarm_melody_sequencer_unit.sv
